// ===== src/pidc_pkg.sv =====
// Package for the discrete PID controller: field widths, fraction format,
// configuration register indexes and internal arithmetic widths.
// No dependencies.
package pidc_pkg;

    // Fixed point format of the gains and of the accumulator.
    localparam int FRACTION_BITS = 8;

    // Widths of the interface fields.
    localparam int DATA_W  = 16;   // setpoint, gains, feedback
    localparam int DRIVE_W = 32;   // drive output
    localparam int CFG_IDX_W = 3;  // configuration register index

    // Widths of the controller state.
    localparam int ERR_W = DATA_W + 1;   // setpoint minus feedback
    localparam int SUM_W = 32;           // saturating error sum
    localparam int ACC_W = 48;           // accumulator with fraction bits

    // Widths of the intermediate arithmetic.
    localparam int D1_W   = ERR_W + 1;       // first difference of the error
    localparam int D2_W   = ERR_W + 2;       // second difference of the error
    localparam int CALC_W = ACC_W + 3;       // headroom before saturation
    localparam int Q_W    = ACC_W - FRACTION_BITS;  // accumulator integer part

    // Rounding bias that turns an arithmetic shift into truncation toward zero.
    localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << FRACTION_BITS) - ACC_W'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_MODE     = 3'd4
    } cfg_index_t;

endpackage

// ===== src/pid_controller_incr_or_positional_top.sv =====
// Top level of the discrete PID controller, incremental or positional form.
// Depends on pidc_pkg for widths, the fraction format and register indexes.
//
// Usage:
// Feedback samples enter on the s_ channel (s_valid/s_ready, s_feedback) and
// one drive value per item leaves on the m_ channel (m_valid/m_ready,
// m_drive). Gains, setpoint and mode are written through cfg_we, cfg_addr
// and cfg_wdata while no item is in flight; writes to unused indexes are
// ignored.
// The block is a three-stage pipeline: an input register, the update stage
// (error, three parallel multiplies, sum and saturation, state write) and
// the drive register (truncation toward zero and 32-bit saturation). An item
// accepted into the input register passes the update stage and then the drive
// register on its way to m_drive, and one item per cycle is taken while the
// receiver keeps up; the sustained rate is set by the single update stage, which closes the state loop.
// When the receiver stalls, m_valid and m_drive hold and the stages behind
// fill up; s_ready drops only once all three stages hold an item.
// Synchronous active-low reset clears the pipeline, the accumulator, the
// error sum and the error history, sets the gains and setpoint to zero and
// selects the incremental form.
module pid_controller_incr_or_positional_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pidc_pkg::DATA_W-1:0]          cfg_wdata,
    // Input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pidc_pkg::DATA_W-1:0]   s_feedback,
    // Result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pidc_pkg::DRIVE_W-1:0]  m_drive
);

    localparam int DATA_W  = pidc_pkg::DATA_W;
    localparam int DRIVE_W = pidc_pkg::DRIVE_W;
    localparam int ERR_W   = pidc_pkg::ERR_W;
    localparam int SUM_W   = pidc_pkg::SUM_W;
    localparam int ACC_W   = pidc_pkg::ACC_W;
    localparam int D1_W    = pidc_pkg::D1_W;
    localparam int D2_W    = pidc_pkg::D2_W;
    localparam int CALC_W  = pidc_pkg::CALC_W;
    localparam int Q_W     = pidc_pkg::Q_W;
    localparam int PI_W    = DATA_W + SUM_W;   // integral product width
    localparam int PP_W    = DATA_W + D1_W;    // proportional product width
    localparam int PD_W    = DATA_W + D2_W;    // derivative product width

    // Signed limits of the accumulator and of the drive output.
    localparam logic signed [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W - 1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W - 1){1'b0}}};

    // Configuration registers
    logic signed [DATA_W-1:0] setpoint_reg;
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic                     mode_incremental_reg;

    // Pipeline registers
    logic                     in_valid_reg;
    logic signed [DATA_W-1:0] in_feedback_reg;
    logic                     upd_valid_reg;
    logic                     m_valid_reg;
    logic signed [DRIVE_W-1:0] m_drive_reg;

    // Controller state
    logic signed [ACC_W-1:0]  accumulator_reg, accumulator_next;
    logic signed [SUM_W-1:0]  error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]  last_error_reg, last_error_next;
    logic signed [ERR_W-1:0]  prior_error_reg, prior_error_next;

    // Handshake and stage advance
    logic out_adv;
    logic upd_ready;
    logic upd_adv;
    logic in_adv;

    // Update stage datapath
    logic signed [ERR_W-1:0]  err;
    logic signed [D1_W-1:0]   diff1;
    logic signed [D2_W-1:0]   diff2;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [D1_W-1:0]   op_p;
    logic signed [SUM_W-1:0]  op_i;
    logic signed [D2_W-1:0]   op_d;
    logic signed [PP_W-1:0]   prod_p;
    logic signed [PI_W-1:0]   prod_i;
    logic signed [PD_W-1:0]   prod_d;
    logic signed [CALC_W-1:0] terms;
    logic signed [CALC_W-1:0] acc_wide;

    // Drive stage datapath
    logic signed [ACC_W-1:0]  acc_biased;
    logic signed [Q_W-1:0]    acc_int;
    logic signed [DRIVE_W-1:0] drive_next;

    // Stage advance: each stage moves on when the one ahead is empty or moving.
    assign out_adv   = upd_valid_reg && (!m_valid_reg || m_ready);
    assign upd_ready = !upd_valid_reg || out_adv;
    assign upd_adv   = in_valid_reg && upd_ready;
    assign s_ready   = !in_valid_reg || upd_adv;
    assign in_adv    = s_valid && s_ready;

    assign m_valid = m_valid_reg;
    assign m_drive = m_drive_reg;

    // Error and its differences for the current item.
    always_comb begin
        err   = ERR_W'(setpoint_reg) - ERR_W'(in_feedback_reg);
        diff1 = D1_W'(err) - D1_W'(last_error_reg);
        diff2 = D2_W'(err) - (D2_W'(last_error_reg) <<< 1) + D2_W'(prior_error_reg);
    end

    // Saturating error sum, used by the positional form only.
    always_comb begin
        sum_wide = (SUM_W + 1)'(error_sum_reg) + (SUM_W + 1)'(err);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                      : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Three shared multipliers; the mode picks each gain's operand.
    always_comb begin
        if (mode_incremental_reg) begin
            op_p = diff1;
            op_i = SUM_W'(err);
            op_d = diff2;
        end else begin
            op_p = D1_W'(err);
            op_i = sum_sat;
            op_d = D2_W'(diff1);
        end
        prod_p = PP_W'(gain_p_reg) * PP_W'(op_p);
        prod_i = PI_W'(gain_i_reg) * PI_W'(op_i);
        prod_d = PD_W'(gain_d_reg) * PD_W'(op_d);
        terms  = CALC_W'(prod_p) + CALC_W'(prod_i) + CALC_W'(prod_d);
    end

    // New accumulator value, saturated to its own width.
    always_comb begin
        if (mode_incremental_reg) begin
            acc_wide = CALC_W'(accumulator_reg) + terms;
        end else begin
            acc_wide = terms;
        end
        if (acc_wide > CALC_W'(ACC_MAX)) begin
            accumulator_next = ACC_MAX;
        end else if (acc_wide < CALC_W'(ACC_MIN)) begin
            accumulator_next = ACC_MIN;
        end else begin
            accumulator_next = acc_wide[ACC_W-1:0];
        end
    end

    // History and error sum updates per form.
    always_comb begin
        last_error_next = err;
        if (mode_incremental_reg) begin
            error_sum_next   = error_sum_reg;
            prior_error_next = last_error_reg;
        end else begin
            error_sum_next   = sum_sat;
            prior_error_next = prior_error_reg;
        end
    end

    // Drive: integer part truncated toward zero, then saturated to 32 bits.
    always_comb begin
        acc_biased = accumulator_reg[ACC_W-1] ? accumulator_reg + ACC_W'(pidc_pkg::FRAC_MASK)
                                              : accumulator_reg;
        acc_int = acc_biased[ACC_W-1:pidc_pkg::FRACTION_BITS];
        if (acc_int > Q_W'(DRIVE_MAX)) begin
            drive_next = DRIVE_MAX;
        end else if (acc_int < Q_W'(DRIVE_MIN)) begin
            drive_next = DRIVE_MIN;
        end else begin
            drive_next = acc_int[DRIVE_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg         <= '0;
            gain_p_reg           <= '0;
            gain_i_reg           <= '0;
            gain_d_reg           <= '0;
            mode_incremental_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (pidc_pkg::cfg_index_t'(cfg_addr))
                pidc_pkg::REG_SETPOINT: setpoint_reg         <= cfg_wdata;
                pidc_pkg::REG_GAIN_P:   gain_p_reg           <= cfg_wdata;
                pidc_pkg::REG_GAIN_I:   gain_i_reg           <= cfg_wdata;
                pidc_pkg::REG_GAIN_D:   gain_d_reg           <= cfg_wdata;
                pidc_pkg::REG_MODE:     mode_incremental_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline valid bits and controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            upd_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            accumulator_reg <= '0;
            error_sum_reg   <= '0;
            last_error_reg  <= '0;
            prior_error_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (upd_ready) begin
                upd_valid_reg <= in_valid_reg;
            end
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= upd_valid_reg;
            end
            if (upd_adv) begin
                accumulator_reg <= accumulator_next;
                error_sum_reg   <= error_sum_next;
                last_error_reg  <= last_error_next;
                prior_error_reg <= prior_error_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_adv) begin
            in_feedback_reg <= s_feedback;
        end
        if (out_adv) begin
            m_drive_reg <= drive_next;
        end
    end

    // An empty input stage always takes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but s_ready low");

    // The controller state moves only when an item passes the update stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !upd_adv |=> $stable(accumulator_reg) && $stable(error_sum_reg)
                     && $stable(last_error_reg) && $stable(prior_error_reg))
        else $error("controller state changed without an item");

    // The positional form leaves the older error untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        upd_adv && !mode_incremental_reg |=> $stable(prior_error_reg))
        else $error("positional step changed prior error");

    // A result appears only after an item sat in the update stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(upd_valid_reg))
        else $error("result valid without an item in the update stage");

endmodule

// ===== verif/pidc_drive_checker.sv =====
`timescale 1ns / 1ps
// Drive checker for the discrete PID controller: it predicts every drive value
// from the configuration writes and the accepted feedback items and compares.
// Depends on pidc_pkg for widths, the fraction format and register indexes.
module pidc_drive_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pidc_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [pidc_pkg::DATA_W-1:0]   s_feedback,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [pidc_pkg::DRIVE_W-1:0]  m_drive,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    localparam int DATA_W        = pidc_pkg::DATA_W;
    localparam int DRIVE_W       = pidc_pkg::DRIVE_W;
    localparam int ERR_W         = pidc_pkg::ERR_W;
    localparam int SUM_W         = pidc_pkg::SUM_W;
    localparam int ACC_W         = pidc_pkg::ACC_W;
    localparam int FRACTION_BITS = pidc_pkg::FRACTION_BITS;

    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -ACC_HI - 1;
    localparam longint SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO   = -SUM_HI - 1;
    localparam longint DRIVE_HI = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_LO = -DRIVE_HI - 1;

    // Shadow copy of the configuration registers.
    logic signed [DATA_W-1:0] setpoint_q;
    logic signed [DATA_W-1:0] kp_q;
    logic signed [DATA_W-1:0] ki_q;
    logic signed [DATA_W-1:0] kd_q;
    logic                     incremental_q;

    // Shadow copy of the controller state.
    logic signed [ACC_W-1:0]  acc_q;
    logic signed [SUM_W-1:0]  err_sum_q;
    logic signed [ERR_W-1:0]  err1_q;
    logic signed [ERR_W-1:0]  err2_q;

    // Drive values still owed by the block, oldest first.
    logic signed [DRIVE_W-1:0] drive_fifo[$];
    logic signed [DRIVE_W-1:0] want_drive;
    int                        errors;
    int                        matched;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // One controller step: updates the shadow state and returns the drive value.
    function automatic logic signed [DRIVE_W-1:0] next_drive(
        input logic signed [DATA_W-1:0] fb
    );
        longint e;
        longint e1;
        longint e2;
        longint delta;
        longint sum;
        longint q;
        e  = longint'(setpoint_q) - longint'(fb);
        e1 = longint'(err1_q);
        e2 = longint'(err2_q);
        if (incremental_q) begin
            delta = longint'(kp_q) * (e - e1) + longint'(ki_q) * e
                  + longint'(kd_q) * (e - 2 * e1 + e2);
            acc_q  = ACC_W'(clip(longint'(acc_q) + delta, ACC_LO, ACC_HI));
            err2_q = err1_q;
            err1_q = ERR_W'(e);
        end else begin
            // The positional form leaves the older error untouched.
            sum       = clip(longint'(err_sum_q) + e, SUM_LO, SUM_HI);
            err_sum_q = SUM_W'(sum);
            acc_q     = ACC_W'(clip(longint'(kp_q) * e + longint'(ki_q) * sum
                                    + longint'(kd_q) * (e - e1), ACC_LO, ACC_HI));
            err1_q    = ERR_W'(e);
        end
        // Integer division truncates toward zero.
        q = longint'(acc_q) / (longint'(1) <<< FRACTION_BITS);
        return DRIVE_W'(clip(q, DRIVE_LO, DRIVE_HI));
    endfunction

    // Follow the writes, predict on every accepted item and compare every result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_q    = '0;
            kp_q          = '0;
            ki_q          = '0;
            kd_q          = '0;
            incremental_q = 1'b1;
            acc_q         = '0;
            err_sum_q     = '0;
            err1_q        = '0;
            err2_q        = '0;
            drive_fifo.delete();
            errors        = 0;
            matched       = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    pidc_pkg::REG_SETPOINT: setpoint_q = cfg_wdata;
                    pidc_pkg::REG_GAIN_P:   kp_q = cfg_wdata;
                    pidc_pkg::REG_GAIN_I:   ki_q = cfg_wdata;
                    pidc_pkg::REG_GAIN_D:   kd_q = cfg_wdata;
                    pidc_pkg::REG_MODE:     incremental_q = cfg_wdata[0];
                    default:                ;
                endcase
            end
            if (s_valid && s_ready) begin
                drive_fifo.push_back(next_drive(s_feedback));
            end
            if (m_valid && m_ready) begin
                if (drive_fifo.size() == 0) begin
                    $display("%0t: unexpected drive item %0d with nothing outstanding",
                             $time, m_drive);
                    errors++;
                end else begin
                    want_drive = drive_fifo.pop_front();
                    if (m_drive !== want_drive) begin
                        $display("%0t: drive mismatch: expected %0d, got %0d",
                                 $time, want_drive, m_drive);
                        errors++;
                    end else begin
                        matched++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= drive_fifo.size();
        checked    <= matched;
    end

endmodule

// ===== verif/pid_controller_incr_or_positional_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the discrete PID controller: drives configuration and
// feedback items, stalls the result side, and reports the verdict.
// Depends on pidc_pkg, the controller top level and pidc_drive_checker.
module pid_controller_incr_or_positional_top_tb;

    localparam int DATA_W    = pidc_pkg::DATA_W;
    localparam int DRIVE_W   = pidc_pkg::DRIVE_W;
    localparam int CFG_IDX_W = pidc_pkg::CFG_IDX_W;

    localparam int          IDLE_PCT      = 13;
    localparam int          PIPE_DEPTH    = 3;
    localparam int          HOLD_CYCLES   = 60;
    localparam int          RAND_SEGMENTS = 6;
    localparam int          SEG_ITEMS     = 50;
    localparam int          SOAK_ITEMS    = 280;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    localparam logic signed [DATA_W-1:0] FB_MIN = 16'sh8000;
    localparam logic signed [DATA_W-1:0] FB_MAX = 16'sh7FFF;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(pidc_pkg::REG_MODE + 1);
    localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG  = '1;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_addr;
    logic [DATA_W-1:0]           cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [DATA_W-1:0]    s_feedback;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [DRIVE_W-1:0]   m_drive;

    int                          fail_count;
    int                          pending;
    int                          checked;
    int                          tx_idle_pct = IDLE_PCT;
    int                          rx_idle_pct = IDLE_PCT;
    int                          rx_hold_left = 0;
    int                          items_sent = 0;
    int unsigned                 cycle_count = 0;
    logic signed [DATA_W-1:0]    cur_setpoint = '0;

    pid_controller_incr_or_positional_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_feedback (s_feedback),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive)
    );

    pidc_drive_checker drive_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_feedback (s_feedback),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d drive items outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one feedback item, sometimes after first dropping s_valid, and wait until taken.
    task automatic send_feedback(input logic signed [DATA_W-1:0] fb);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_feedback <= fb;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stop offering and wait until every drive item has come back.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 1) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // Write every register, plus one unused index that the block must ignore.
    task automatic configure(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] kp,
                             input logic [DATA_W-1:0] ki, input logic [DATA_W-1:0] kd,
                             input logic incremental);
        write_reg(pidc_pkg::REG_SETPOINT, sp);
        write_reg(pidc_pkg::REG_GAIN_P, kp);
        write_reg(pidc_pkg::REG_GAIN_I, ki);
        write_reg(pidc_pkg::REG_GAIN_D, kd);
        // Only bit 0 selects the form; the upper bits are noise.
        write_reg(pidc_pkg::REG_MODE, {(DATA_W - 1)'($urandom), incremental});
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                  DATA_W'($urandom));
        cfg_we       <= 1'b0;
        cur_setpoint = sp;
    endtask

    function automatic logic [DATA_W-1:0] pick_reg_value();
        case ($urandom_range(5))
            0:       return FB_MIN;
            1:       return FB_MAX;
            2:       return '0;
            3:       return DATA_W'(int'($urandom_range(1024)) - 512);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_feedback();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? FB_MAX : FB_MIN;
            1, 2:    return DATA_W'(int'(cur_setpoint) + int'($urandom_range(64)) - 32);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int seg;
        int n;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_feedback = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: zero gains, incremental form.
        send_feedback(FB_MIN);
        send_feedback(FB_MAX);
        wait_for_drain();

        // Moderate gains, feedback extremes and a sample on the setpoint.
        configure(16'd1000, 16'h0180, 16'h0040, 16'h0100, 1'b1);
        send_feedback(FB_MIN);
        send_feedback(FB_MAX);
        send_feedback(16'sd0);
        send_feedback(16'sd1000);
        send_feedback(-16'sd1);
        wait_for_drain();

        // Largest gains against the widest swings of the error.
        configure(FB_MAX, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
        send_feedback(FB_MIN);
        send_feedback(FB_MAX);
        send_feedback(FB_MIN);
        wait_for_drain();

        // Positional form: the older error must not move.
        configure(FB_MIN, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        send_feedback(FB_MAX);
        send_feedback(FB_MIN);
        send_feedback(16'sd0);
        send_feedback(FB_MAX);
        wait_for_drain();

        // Back to incremental: the state carries over from the positional steps.
        configure(-16'sd5, 16'h0100, 16'h0001, 16'hFF00, 1'b1);
        send_feedback(-16'sd3);
        send_feedback(16'sd7);
        send_feedback(FB_MAX);
        wait_for_drain();

        // Half gain on odd errors: negative fractions truncate toward zero.
        configure(16'd0, 16'h0080, 16'h0000, 16'h0000, 1'b0);
        send_feedback(16'sd3);
        send_feedback(-16'sd3);
        send_feedback(16'sd1);
        wait_for_drain();

        // A run at full error in the positional form drives the output to its
        // positive limit.
        configure(FB_MAX, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
        for (n = 0; n < SOAK_ITEMS; n++) send_feedback(FB_MIN);
        wait_for_drain();

        // Negative gain on the large error sum: the output goes to its low limit.
        configure(FB_MAX, 16'h0000, 16'h8000, 16'h0000, 1'b0);
        send_feedback(FB_MIN);
        wait_for_drain();

        // Random settings and feedback, the first segment without any idling.
        for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
            tx_idle_pct = (seg == 0) ? 0 : IDLE_PCT;
            rx_idle_pct = (seg == 0) ? 0 : IDLE_PCT;
            configure(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                      pick_reg_value(), 1'($urandom_range(1)));
            // Hold the result side off so the pipeline fills and stalls the input.
            if (seg == 2) rx_hold_left = HOLD_CYCLES;
            for (n = 0; n < SEG_ITEMS; n++) send_feedback(pick_feedback());
            wait_for_drain();
        end

        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        $display("Sent %0d feedback items and matched %0d drive items in both forms,",
                 items_sent, checked);
        $display("with stalls, a long hold-off and the drive held at both of its limits.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/pidc_pkg.sv
src/pid_controller_incr_or_positional_top.sv
verif/pidc_drive_checker.sv
verif/pid_controller_incr_or_positional_top_tb.sv
